### rtl/size_class_pool_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SIZE_CLASS_POOL_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
`define SCPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SCPA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SCPA_ASSERT(lbl, prop, msg)
`define SCPA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### rtl/scpa_pkg.sv
// Types, codes and helper functions of the size-class pool allocator.
// No dependencies; imported by every allocator module but scpa_ram.
package scpa_pkg;

    localparam int ADDR_W   = 20;
    localparam int SIZE_W   = 32;
    localparam int CAP_W    = 13;
    localparam int CLS_W    = 6;
    localparam int WIDX_W   = 17;
    localparam int TAKEN_W  = 3;
    localparam int BYTES_W  = CAP_W + 1;
    localparam int CAP_MAX  = 4096;
    localparam int HDR_BYTES = 8;

    localparam int SLAB_BYTES_DEF  = 262144;
    localparam int NUM_SLABS_DEF   = 4;
    localparam int CLASS_COUNT_DEF = 60;
    localparam logic [CAP_W-1:0] SMALL_LIMIT_RST = 13'd4096;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_RESIZE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOMEM = 2'd1,
        ST_TOOBIG = 2'd2
    } status_t;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [CAP_W-1:0]  size13;
        logic              big;
        logic              too_large;
        logic              zero;
        logic [CLS_W-1:0]  cls;
    } req_t;

    function automatic logic [CAP_W-1:0] class_cap(input logic [CLS_W-1:0] cls);
        logic [CAP_W-1:0] c;
        begin
            c = CAP_W'(cls);
            if (cls <= CLS_W'(32))
                class_cap = c << 4;
            else
                class_cap = CAP_W'(512) + ((c - CAP_W'(32)) << 7);
        end
    endfunction

    function automatic logic [WIDX_W-1:0] word_index(input logic [ADDR_W-1:0] a);
        word_index = a[ADDR_W-1:3];
    endfunction

endpackage

### rtl/scpa_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; used for the list heads and the block words.
module scpa_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/scpa_front.sv
// Front end: takes requests, registers them and works out class and limit flags.
// Depends on scpa_pkg.
module scpa_front import scpa_pkg::*; #(
    parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [SIZE_W-1:0]  size,
    input  logic [ADDR_W-1:0]  address,
    input  logic [CAP_W-1:0]   small_limit,
    output logic               q_valid,
    input  logic               q_ready,
    output req_t               q_data
);

    localparam logic [CAP_W-1:0] CAP_TOP = class_cap(CLS_W'(CLASS_COUNT));

    logic              stg_valid_reg;
    logic [1:0]        stg_op_reg;
    logic [SIZE_W-1:0] stg_size_reg;
    logic [ADDR_W-1:0] stg_addr_reg;

    logic [CAP_W-1:0]  limit;
    logic [CAP_W-1:0]  s13;
    logic [CAP_W-1:0]  small_c;
    logic [CAP_W-1:0]  large_c;
    logic [CLS_W-1:0]  cls;

    assign in_ready = !stg_valid_reg || q_ready;
    assign q_valid  = stg_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            stg_valid_reg <= 1'b1;
        else if (q_ready)
            stg_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stg_op_reg   <= op;
            stg_size_reg <= size;
            stg_addr_reg <= address;
        end
    end

    // Sizes above the largest class are never classified usefully: they are
    // always over the limit, so their class is a don't-care.
    always_comb
    begin
        limit   = (small_limit < CAP_TOP) ? small_limit : CAP_TOP;
        s13     = stg_size_reg[CAP_W-1:0];
        small_c = (s13 + CAP_W'(15)) >> 4;
        large_c = (s13 - CAP_W'(385)) >> 7;
        if (s13 <= CAP_W'(512))
            cls = (small_c == '0) ? CLS_W'(1) : small_c[CLS_W-1:0];
        else
            cls = CLS_W'(32) + large_c[CLS_W-1:0];
        q_data.op        = op_t'(stg_op_reg);
        q_data.addr      = stg_addr_reg;
        q_data.size13    = s13;
        q_data.big       = stg_size_reg > SIZE_W'(CAP_MAX);
        q_data.too_large = stg_size_reg > SIZE_W'(limit);
        q_data.zero      = stg_size_reg == '0;
        q_data.cls       = cls;
    end

endmodule

### rtl/scpa_fifo.sv
// Two-entry request queue between the front end and the back end.
// Depends on scpa_pkg for the request type.
module scpa_fifo import scpa_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  req_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output req_t pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    req_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != (PTR_W+1)'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (PTR_W+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/scpa_back.sv
// Back end: sequencer over the list-head and block-word memories, slab carving
// and the result register. Depends on scpa_pkg, scpa_ram and the defines header.
`include "size_class_pool_allocator_defines.svh"
module scpa_back import scpa_pkg::*; #(
    parameter int SLAB_BYTES  = SLAB_BYTES_DEF,
    parameter int NUM_SLABS   = NUM_SLABS_DEF,
    parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  req_t              q_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] result_address,
    output logic [CAP_W-1:0]  capacity,
    output logic              moved,
    output logic [CAP_W-1:0]  copy_bytes
);

    localparam int HIDX_W = $clog2(CLASS_COUNT);
    localparam int REM_W  = $clog2(SLAB_BYTES + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_AHEAD = 7'b0000010,
        S_ALINK = 7'b0000100,
        S_HDR   = 7'b0001000,
        S_FREAD = 7'b0010000,
        S_FHEAD = 7'b0100000,
        S_PUSH  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    req_t   cur_reg, cur_next;
    logic [CLS_W-1:0]  ocls_reg, ocls_next;
    logic [CAP_W-1:0]  ocap_reg, ocap_next;
    logic              move_reg, move_next;
    status_t           rs_status_reg, rs_status_next;
    logic [ADDR_W-1:0] rs_addr_reg, rs_addr_next;
    logic [CAP_W-1:0]  rs_cap_reg, rs_cap_next;
    logic              rs_moved_reg, rs_moved_next;
    logic [CAP_W-1:0]  rs_copy_reg, rs_copy_next;
    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [TAKEN_W-1:0] taken_reg, taken_next;
    logic [CLASS_COUNT-1:0] hv_reg;
    logic              hv_q_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [CAP_W-1:0]  out_cap_reg;
    logic              out_moved_reg;
    logic [CAP_W-1:0]  out_copy_reg;
    logic              out_load;

    logic              h_we;
    logic [HIDX_W-1:0] h_addr;
    logic [ADDR_W-1:0] h_wdata;
    logic [ADDR_W-1:0] h_rdata;
    logic              w_we;
    logic [WIDX_W-1:0] w_addr;
    logic [ADDR_W-1:0] w_wdata;
    logic [ADDR_W-1:0] w_rdata;

    logic [ADDR_W-1:0]  head_val;
    logic [CLS_W-1:0]   hdr_cls;
    logic [BYTES_W-1:0] bytes;
    logic               need_new;
    logic               pool_full;
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  cur_eff;
    logic [REM_W-1:0]   rem_eff;
    logic               alloc_like;

    scpa_ram #(.WIDTH(ADDR_W), .DEPTH(CLASS_COUNT)) u_heads (
        .clk   (clk),
        .we    (h_we),
        .addr  (h_addr),
        .wdata (h_wdata),
        .rdata (h_rdata)
    );

    scpa_ram #(.WIDTH(ADDR_W), .DEPTH(2 ** WIDX_W)) u_words (
        .clk   (clk),
        .we    (w_we),
        .addr  (w_addr),
        .wdata (w_wdata),
        .rdata (w_rdata)
    );

    // A head that was never written reads as an empty list.
    assign head_val = hv_q_reg ? h_rdata : '0;

    always_comb
    begin
        hdr_cls = ((w_rdata >= ADDR_W'(1)) && (w_rdata <= ADDR_W'(CLASS_COUNT)))
                  ? w_rdata[CLS_W-1:0] : '0;
        bytes     = BYTES_W'(HDR_BYTES) + BYTES_W'(class_cap(cur_reg.cls));
        need_new  = 32'(rem_reg) < 32'(bytes);
        pool_full = 32'(taken_reg) >= 32'(NUM_SLABS);
        base      = ADDR_W'(32'(taken_reg) * 32'(SLAB_BYTES));
        cur_eff   = need_new ? base : cursor_reg;
        rem_eff   = need_new ? REM_W'(SLAB_BYTES) : rem_reg;
        alloc_like = (q_data.op == OP_ALLOC) ||
                     ((q_data.op == OP_RESIZE) && (q_data.addr == '0));
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        ocls_next      = ocls_reg;
        ocap_next      = ocap_reg;
        move_next      = move_reg;
        rs_status_next = rs_status_reg;
        rs_addr_next   = rs_addr_reg;
        rs_cap_next    = rs_cap_reg;
        rs_moved_next  = rs_moved_reg;
        rs_copy_next   = rs_copy_reg;
        cursor_next    = cursor_reg;
        rem_next       = rem_reg;
        taken_next     = taken_reg;
        q_ready        = 1'b0;
        out_load       = 1'b0;
        h_we           = 1'b0;
        h_addr         = HIDX_W'(cur_reg.cls - CLS_W'(1));
        h_wdata        = cur_reg.addr;
        w_we           = 1'b0;
        w_addr         = word_index(cur_reg.addr);
        w_wdata        = ADDR_W'(cur_reg.cls);

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_ready        = 1'b1;
                    cur_next       = q_data;
                    move_next      = 1'b0;
                    ocls_next      = '0;
                    ocap_next      = '0;
                    rs_status_next = ST_OK;
                    rs_addr_next   = '0;
                    rs_cap_next    = '0;
                    rs_moved_next  = 1'b0;
                    rs_copy_next   = '0;
                    h_addr         = HIDX_W'(q_data.cls - CLS_W'(1));
                    w_addr         = word_index(q_data.addr - ADDR_W'(HDR_BYTES));
                    if (alloc_like)
                    begin
                        if (q_data.too_large)
                        begin
                            rs_status_next = ST_TOOBIG;
                            state_next     = S_PUSH;
                        end
                        else
                            state_next = S_AHEAD;
                    end
                    else if (q_data.addr == '0)
                        state_next = S_PUSH;
                    else
                        state_next = S_HDR;
                end
            end

            S_HDR:
            begin
                ocls_next = hdr_cls;
                ocap_next = class_cap(hdr_cls);
                if (cur_reg.op == OP_QUERY)
                begin
                    rs_cap_next = class_cap(hdr_cls);
                    state_next  = S_PUSH;
                end
                else if (cur_reg.op == OP_RELEASE || cur_reg.zero)
                begin
                    h_addr     = HIDX_W'(hdr_cls - CLS_W'(1));
                    state_next = (hdr_cls != '0) ? S_FHEAD : S_PUSH;
                end
                else if (!cur_reg.big && cur_reg.size13 <= class_cap(hdr_cls))
                begin
                    rs_addr_next = cur_reg.addr;
                    rs_cap_next  = class_cap(hdr_cls);
                    state_next   = S_PUSH;
                end
                else if (cur_reg.too_large)
                begin
                    rs_status_next = ST_TOOBIG;
                    state_next     = S_PUSH;
                end
                else
                begin
                    move_next  = 1'b1;
                    state_next = S_AHEAD;
                end
            end

            S_AHEAD:
            begin
                rs_cap_next = class_cap(cur_reg.cls);
                if (head_val != '0)
                begin
                    // Pop: fetch the link word held in the free block.
                    rs_addr_next = head_val;
                    w_addr       = word_index(head_val);
                    state_next   = S_ALINK;
                end
                else if (need_new && pool_full)
                begin
                    rs_status_next = ST_NOMEM;
                    rs_cap_next    = '0;
                    state_next     = S_PUSH;
                end
                else
                begin
                    if (need_new)
                        taken_next = taken_reg + TAKEN_W'(1);
                    w_we         = 1'b1;
                    w_addr       = word_index(cur_eff);
                    cursor_next  = cur_eff + ADDR_W'(bytes);
                    rem_next     = rem_eff - REM_W'(bytes);
                    rs_addr_next = cur_eff + ADDR_W'(HDR_BYTES);
                    if (move_reg)
                    begin
                        rs_moved_next = 1'b1;
                        rs_copy_next  = ocap_reg;
                        state_next    = (ocls_reg != '0) ? S_FREAD : S_PUSH;
                    end
                    else
                        state_next = S_PUSH;
                end
            end

            S_ALINK:
            begin
                h_we    = 1'b1;
                h_wdata = w_rdata;
                w_we    = 1'b1;
                w_addr  = word_index(rs_addr_reg - ADDR_W'(HDR_BYTES));
                if (move_reg)
                begin
                    rs_moved_next = 1'b1;
                    rs_copy_next  = ocap_reg;
                    state_next    = (ocls_reg != '0) ? S_FREAD : S_PUSH;
                end
                else
                    state_next = S_PUSH;
            end

            S_FREAD:
            begin
                h_addr     = HIDX_W'(ocls_reg - CLS_W'(1));
                state_next = S_FHEAD;
            end

            S_FHEAD:
            begin
                // Push the released block: its first word links to the old head.
                h_we       = 1'b1;
                h_addr     = HIDX_W'(ocls_reg - CLS_W'(1));
                h_wdata    = cur_reg.addr;
                w_we       = 1'b1;
                w_addr     = word_index(cur_reg.addr);
                w_wdata    = head_val;
                state_next = S_PUSH;
            end

            S_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            rem_reg       <= '0;
            taken_reg     <= '0;
            hv_reg        <= '0;
            hv_q_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            rem_reg    <= rem_next;
            taken_reg  <= taken_next;
            hv_q_reg   <= hv_reg[h_addr];
            if (h_we)
                hv_reg[h_addr] <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        ocls_reg      <= ocls_next;
        ocap_reg      <= ocap_next;
        move_reg      <= move_next;
        rs_status_reg <= rs_status_next;
        rs_addr_reg   <= rs_addr_next;
        rs_cap_reg    <= rs_cap_next;
        rs_moved_reg  <= rs_moved_next;
        rs_copy_reg   <= rs_copy_next;
        if (out_load)
        begin
            out_status_reg <= rs_status_reg;
            out_addr_reg   <= rs_addr_reg;
            out_cap_reg    <= rs_cap_reg;
            out_moved_reg  <= rs_moved_reg;
            out_copy_reg   <= rs_copy_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign result_address = out_addr_reg;
    assign capacity       = out_cap_reg;
    assign moved          = out_moved_reg;
    assign copy_bytes     = out_copy_reg;

    `SCPA_ASSERT(a_pop_idle, q_ready |-> state_reg == S_IDLE, "queue popped while busy")
    `SCPA_ASSERT(a_head_wr, h_we |-> (state_reg == S_ALINK || state_reg == S_FHEAD),
        "list head written outside a push or pop")
    `SCPA_ASSERT(a_fail_null, (out_load && rs_status_reg != ST_OK) |-> rs_addr_reg == '0,
        "failed request carries an address")
    `SCPA_ASSERT(a_rem_bound, 32'(rem_reg) <= 32'(SLAB_BYTES), "slab remainder too large")
    `SCPA_ASSERT_NEXT(a_load_valid, out_load, out_valid_reg, "result load lost")

endmodule

### rtl/size_class_pool_allocator.sv
// Top level of the size-class pool allocator.
// Depends on scpa_pkg, scpa_front, scpa_fifo and scpa_back.
//
// Requests (op, size, address) enter on in_valid/in_ready; one result per
// request (status, result_address, capacity, moved, copy_bytes) leaves on
// out_valid/out_ready in request order. small_limit is written through
// cfg_write/cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce. A request is registered
// in the front stage, passes a two-entry queue and is run by the back-end
// sequencer, whose single-port head and block-word memories set the pace:
// a rejected or null request goes straight to the result, a query reads
// the header, an allocate pops or carves a block, a release pushes one
// and a moving resize does both; the result register is loaded in the
// last state and the back end then takes the next request. Reset empties
// every free list, clears the slab cursor and count and sets
// small_limit to 4096; no clearing pass is needed. If the receiver stalls
// the result register holds, the back end waits with the next result and
// the front stage and queue keep taking up to three further requests.
module size_class_pool_allocator import scpa_pkg::*; #(
    parameter int SLAB_BYTES  = SLAB_BYTES_DEF,
    parameter int NUM_SLABS   = NUM_SLABS_DEF,
    parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [CAP_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        op,
    input  logic [SIZE_W-1:0] size,
    input  logic [ADDR_W-1:0] address,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] result_address,
    output logic [CAP_W-1:0]  capacity,
    output logic              moved,
    output logic [CAP_W-1:0]  copy_bytes
);

    logic [CAP_W-1:0] small_limit_reg;
    logic             f_valid;
    logic             f_ready;
    req_t             f_data;
    logic             b_valid;
    logic             b_ready;
    req_t             b_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            small_limit_reg <= SMALL_LIMIT_RST;
        else if (cfg_write)
            small_limit_reg <= cfg_data;
    end

    scpa_front #(.CLASS_COUNT(CLASS_COUNT)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .size        (size),
        .address     (address),
        .small_limit (small_limit_reg),
        .q_valid     (f_valid),
        .q_ready     (f_ready),
        .q_data      (f_data)
    );

    scpa_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    scpa_back #(
        .SLAB_BYTES  (SLAB_BYTES),
        .NUM_SLABS   (NUM_SLABS),
        .CLASS_COUNT (CLASS_COUNT)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (b_valid),
        .q_ready        (b_ready),
        .q_data         (b_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .result_address (result_address),
        .capacity       (capacity),
        .moved          (moved),
        .copy_bytes     (copy_bytes)
    );

endmodule

### bench/size_class_pool_allocator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for size_class_pool_allocator: directed and random
// allocate, release, query and resize requests checked against a local predictor.
// Depends on scpa_pkg and the allocator RTL only.
module size_class_pool_allocator_tb;
    import scpa_pkg::*;

    typedef struct {
        status_t     st;
        logic [19:0] addr;
        logic [12:0] cap;
        logic        moved;
        logic [12:0] copy;
    } alloc_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic [12:0]       cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        op;
    logic [31:0]       size;
    logic [19:0]       address;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        status;
    logic [19:0]       result_address;
    logic [12:0]       capacity;
    logic              moved;
    logic [12:0]       copy_bytes;

    // Predictor state.
    logic [12:0]       pool_limit;
    logic [19:0]       list_head [0:59];
    logic [19:0]       pool_word [0:131071];
    logic [19:0]       carve_ptr;
    int unsigned       carve_left;
    int unsigned       slabs_used;

    alloc_result_t     expected_q[$];
    alloc_result_t     last_result;
    logic [19:0]       live_q[$];
    int                errors;
    int                hold_len;
    bit                idle_on;

    size_class_pool_allocator u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .size(size), .address(address),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .result_address(result_address), .capacity(capacity),
        .moved(moved), .copy_bytes(copy_bytes)
    );

    always #5 clk = ~clk;

    function automatic int unsigned cls_capacity(input int unsigned cls);
        return cls <= 32 ? cls * 16 : 512 + (cls - 32) * 128;
    endfunction

    function automatic int unsigned cls_for_size(input int unsigned sz);
        if (sz <= 512)
            return sz == 0 ? 1 : (sz + 15) >> 4;
        return 32 + ((sz - 512 + 127) >> 7);
    endfunction

    function automatic int unsigned block_class(input logic [19:0] a);
        logic [19:0] w;
        logic [19:0] h;
        h = a - 20'd8;
        w = pool_word[h[19:3]];
        return (w >= 1 && w <= 60) ? w : 0;
    endfunction

    function automatic status_t carve_block(input int unsigned sz, output logic [19:0] a,
                                            output logic [12:0] cp);
        int unsigned cls;
        int unsigned need;
        int unsigned lim;
        logic [19:0] h;
        lim = pool_limit < 4096 ? pool_limit : 4096;
        a = '0;
        cp = '0;
        if (sz > lim)
            return ST_TOOBIG;
        cls = cls_for_size(sz);
        a = list_head[cls-1];
        if (a != 0) begin
            list_head[cls-1] = pool_word[a[19:3]];
            h = a - 20'd8;
        end else begin
            need = 8 + cls_capacity(cls);
            if (carve_left < need) begin
                if (slabs_used >= 4)
                    return ST_NOMEM;
                carve_ptr = 20'(slabs_used * 262144);
                carve_left = 262144;
                slabs_used++;
            end
            h = carve_ptr;
            carve_ptr = carve_ptr + 20'(need);
            carve_left -= need;
            a = h + 20'd8;
        end
        pool_word[h[19:3]] = 20'(cls);
        cp = 13'(cls_capacity(cls));
        return ST_OK;
    endfunction

    function automatic void release_block(input logic [19:0] a);
        int unsigned cls;
        if (a == 0)
            return;
        cls = block_class(a);
        if (cls == 0)
            return;
        pool_word[a[19:3]] = list_head[cls-1];
        list_head[cls-1] = a;
    endfunction

    function automatic alloc_result_t predict_outcome(input op_t o, input int unsigned sz,
                                                      input logic [19:0] a);
        alloc_result_t r;
        int unsigned ocls;
        int unsigned ocap;
        r = '{ST_OK, '0, '0, 1'b0, '0};
        case (o)
            OP_ALLOC:   r.st = carve_block(sz, r.addr, r.cap);
            OP_RELEASE: release_block(a);
            OP_QUERY:   if (a != 0) r.cap = 13'(block_class(a) == 0 ? 0 :
                                                cls_capacity(block_class(a)));
            default: begin
                if (a == 0)
                    r.st = carve_block(sz, r.addr, r.cap);
                else if (sz == 0)
                    release_block(a);
                else begin
                    ocls = block_class(a);
                    ocap = ocls == 0 ? 0 : cls_capacity(ocls);
                    if (sz <= ocap) begin
                        r.addr = a;
                        r.cap = 13'(ocap);
                    end else begin
                        r.st = carve_block(sz, r.addr, r.cap);
                        if (r.st == ST_OK) begin
                            release_block(a);
                            r.moved = 1'b1;
                            r.copy = 13'(ocap);
                        end
                    end
                end
            end
        endcase
        if (r.st != ST_OK) begin
            r.addr = '0;
            r.cap = '0;
        end
        return r;
    endfunction

    function automatic void drop_live(input logic [19:0] a);
        for (int i = 0; i < live_q.size(); i++)
            if (live_q[i] == a) begin
                live_q.delete(i);
                return;
            end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic send_req(input op_t o, input logic [31:0] sz, input logic [19:0] a);
        alloc_result_t r;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        size <= sz;
        address <= a;
        do @(posedge clk); while (!in_ready);
        r = predict_outcome(o, sz, a);
        expected_q.push_back(r);
        last_result = r;
        // Keep the set of granted addresses in step with the predictor.
        if (r.st == ST_OK) begin
            if (o == OP_ALLOC || (o == OP_RESIZE && a == 0))
                live_q.push_back(r.addr);
            else if ((o == OP_RELEASE || (o == OP_RESIZE && sz == 0)) && a != 0)
                drop_live(a);
            else if (r.moved) begin
                drop_live(a);
                live_q.push_back(r.addr);
            end
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        // Let the bench idle between tests.
        repeat (12) @(posedge clk);
    endtask

    task automatic set_limit(input logic [12:0] v);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        pool_limit = v;
    endtask

    function automatic logic [19:0] pick_live();
        return live_q.size() == 0 ? 20'd0 : live_q[$urandom_range(0, live_q.size() - 1)];
    endfunction

    function automatic logic [31:0] rand_size();
        int unsigned w;
        w = $urandom_range(0, 19);
        if (w < 13) return $urandom_range(0, 512);
        if (w < 17) return $urandom_range(513, 4096);
        if (w < 18) return $urandom_range(4090, 4100);
        return $urandom;
    endfunction

    task automatic test_directed();
        logic [19:0] a;
        send_req(OP_QUERY, 32'd0, 20'd0);
        send_req(OP_RELEASE, 32'hFFFF_FFFF, 20'd0);
        send_req(OP_ALLOC, 32'd0, 20'hFFFFF);
        send_req(OP_ALLOC, 32'd1, 20'h00007);
        send_req(OP_ALLOC, 32'd16, 20'h0);
        send_req(OP_ALLOC, 32'd17, 20'h0);
        send_req(OP_ALLOC, 32'd512, 20'h0);
        send_req(OP_ALLOC, 32'd513, 20'h0);
        send_req(OP_ALLOC, 32'd4096, 20'h0);
        send_req(OP_ALLOC, 32'd4097, 20'h0);
        send_req(OP_ALLOC, 32'hFFFF_FFFF, 20'h0);
        a = live_q[1];
        send_req(OP_QUERY, 32'd0, a);
        // Release then allocate the same class: the freed block comes back first.
        send_req(OP_RELEASE, 32'd0, a);
        send_req(OP_ALLOC, 32'd3, 20'h0);
        send_req(OP_RESIZE, 32'd100, 20'd0);
        a = last_result.addr;
        send_req(OP_RESIZE, 32'd90, a);
        send_req(OP_RESIZE, 32'd2000, a);
        a = last_result.addr;
        send_req(OP_RESIZE, 32'd5000, a);
        send_req(OP_RESIZE, 32'd0, a);
        send_req(OP_QUERY, 32'd0, live_q[0]);
        drain_results();
    endtask

    task automatic test_limit();
        logic [19:0] a;
        set_limit(13'd16);
        send_req(OP_ALLOC, 32'd16, 20'h0);
        a = last_result.addr;
        send_req(OP_ALLOC, 32'd17, 20'h0);
        send_req(OP_RESIZE, 32'd17, a);
        send_req(OP_RESIZE, 32'd17, 20'd0);
        drain_results();
        set_limit(13'h1FFF);
        send_req(OP_ALLOC, 32'd4096, 20'h0);
        send_req(OP_ALLOC, 32'd4097, 20'h0);
        drain_results();
        set_limit(13'($urandom_range(16, 4096)));
        send_req(OP_ALLOC, 32'(pool_limit), 20'h0);
        send_req(OP_ALLOC, 32'(pool_limit) + 1, 20'h0);
        drain_results();
    endtask

    task automatic test_backpressure();
        hold_len = 200;
        for (int i = 0; i < 16; i++)
            send_req(i % 2 ? OP_QUERY : OP_ALLOC, $urandom_range(0, 600), pick_live());
        drain_results();
    endtask

    task automatic test_random(input int n);
        int unsigned w;
        logic [19:0] a;
        for (int i = 0; i < n; i++) begin
            w = $urandom_range(0, 99);
            if (live_q.size() > 48 && w < 40)
                w = 45;
            a = $urandom_range(0, 7) == 0 ? 20'd0 : pick_live();
            if (live_q.size() == 0 || w < 40)
                send_req(OP_ALLOC, rand_size(), 20'($urandom));
            else if (w < 60)
                send_req(OP_RELEASE, $urandom, a);
            else if (w < 75)
                send_req(OP_QUERY, $urandom, a);
            else
                send_req(OP_RESIZE, $urandom_range(0, 9) == 0 ? 32'd0 : rand_size(), a);
        end
        drain_results();
    endtask

    task automatic test_exhaust();
        int misses;
        misses = 0;
        for (int i = 0; i < 400 && misses < 4; i++) begin
            send_req(OP_ALLOC, 32'd4096, 20'h0);
            if (last_result.st == ST_NOMEM)
                misses++;
        end
        drain_results();
    endtask

    // Result checker: every accepted result is matched against the oldest prediction.
    always @(posedge clk) begin
        alloc_result_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0)
                report_mismatch("result with no request outstanding");
            else begin
                e = expected_q.pop_front();
                if (status !== e.st)
                    report_mismatch($sformatf("status %0d, want %0d", status, e.st));
                if (result_address !== e.addr)
                    report_mismatch($sformatf("address %h, want %h", result_address, e.addr));
                if (capacity !== e.cap)
                    report_mismatch($sformatf("capacity %0d, want %0d", capacity, e.cap));
                if (moved !== e.moved)
                    report_mismatch($sformatf("moved %b, want %b", moved, e.moved));
                if (copy_bytes !== e.copy)
                    report_mismatch($sformatf("copy %0d, want %0d", copy_bytes, e.copy));
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold when a test asks for one.
    initial begin
        int stall;
        stall = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_len > 0) begin
                out_ready <= 1'b0;
                hold_len--;
            end else if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                stall = $urandom_range(0, 6);
            end else
                out_ready <= 1'b1;
        end
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = '0;
        size = '0;
        address = '0;
        errors = 0;
        hold_len = 0;
        idle_on = 1'b1;
        pool_limit = 13'd4096;
        carve_ptr = '0;
        carve_left = 0;
        slabs_used = 0;
        for (int i = 0; i < 60; i++)
            list_head[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_limit();
        test_backpressure();
        set_limit(13'd4096);
        test_random(400);
        set_limit(13'($urandom_range(16, 4096)));
        test_random(400);
        set_limit(13'd600);
        test_random(400);
        set_limit(13'h1FFF);
        idle_on = 1'b0;
        test_random(400);
        test_exhaust();

        if (errors == 0 && expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/scpa_pkg.sv
rtl/scpa_ram.sv
rtl/scpa_front.sv
rtl/scpa_fifo.sv
rtl/scpa_back.sv
rtl/size_class_pool_allocator.sv
bench/size_class_pool_allocator_tb.sv
